// ===== design/rpct_pkg.sv =====
// Shared types and constants for the red pixel cluster tracker.
// No dependencies; the input stage, tracker, report and top-level files import this package.
package rpct_pkg;

	localparam int unsigned CFG_INDEX_BITS = 2;
	localparam int unsigned CFG_DATA_BITS  = 10;
	localparam int unsigned CHAN_BITS      = 8;
	localparam int unsigned LEVEL_BITS     = 9;
	localparam int unsigned RADIUS_BITS    = 10;
	localparam int unsigned LIM_BITS       = 2 * RADIUS_BITS;

	localparam logic [CHAN_BITS-1:0]   RED_MIN_RST   = 8'd200;
	localparam logic [LEVEL_BITS-1:0]  GREEN_MAX_RST = 9'd50;
	localparam logic [LEVEL_BITS-1:0]  BLUE_MAX_RST  = 9'd50;
	localparam logic [RADIUS_BITS-1:0] RADIUS_RST    = 10'd50;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_RED_MIN      = 2'd0,
		CFG_GREEN_MAX    = 2'd1,
		CFG_BLUE_MAX     = 2'd2,
		CFG_MATCH_RADIUS = 2'd3
	} cfg_reg_t;

	// Control of the pixel held in the input register, as seen by the slot logic.
	typedef struct packed {
		logic go;          // pixel leaves the input register this cycle
		logic is_red;
		logic frame_start;
		logic frame_end;
	} pix_ctl_t;

	function automatic logic [LIM_BITS-1:0] radius_sq(input logic [RADIUS_BITS-1:0] r);
		return LIM_BITS'(r) * LIM_BITS'(r);
	endfunction

	localparam logic [LIM_BITS-1:0] LIM_RST = radius_sq(RADIUS_RST);

endpackage

// ===== design/rpct_ifs.sv =====
// Valid/ready channel interfaces: pixel beats in, slot report beats out.
// No dependencies.
interface pix_if #(
	parameter int unsigned COORD_BITS = 10
);
	logic                  valid;
	logic                  ready;
	logic [7:0]            red;
	logic [7:0]            green;
	logic [7:0]            blue;
	logic [COORD_BITS-1:0] col;
	logic [COORD_BITS-1:0] row;
	logic                  frame_start;
	logic                  frame_end;

	modport source (output valid, red, green, blue, col, row, frame_start, frame_end,
		input ready);
	modport sink (input valid, red, green, blue, col, row, frame_start, frame_end,
		output ready);
endinterface

interface rpt_if #(
	parameter int unsigned SLOT_BITS  = 2,
	parameter int unsigned COORD_BITS = 10,
	parameter int unsigned COUNT_BITS = 20
);
	logic                  valid;
	logic                  ready;
	logic [SLOT_BITS-1:0]  slot_index;
	logic [COORD_BITS-1:0] center_col;
	logic [COORD_BITS-1:0] center_row;
	logic [COUNT_BITS-1:0] hit_count;
	logic [COUNT_BITS-1:0] dropped;
	logic                  last;

	modport source (output valid, slot_index, center_col, center_row, hit_count, dropped,
		last, input ready);
	modport sink (input valid, slot_index, center_col, center_row, hit_count, dropped,
		last, output ready);
endinterface

// ===== design/rpct_input_stage.sv =====
// Input register of the tracker: takes pixel beats and classifies red.
// Depends on rpct_pkg and pix_if.
module rpct_input_stage import rpct_pkg::*; #(
	parameter int unsigned COORD_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	pix_if.sink                   pixel,
	input  logic [CHAN_BITS-1:0]  red_min,
	input  logic [LEVEL_BITS-1:0] green_max,
	input  logic [LEVEL_BITS-1:0] blue_max,
	input  logic                  rep_busy,
	output pix_ctl_t              ctl,
	output logic [COORD_BITS-1:0] col_s1,
	output logic [COORD_BITS-1:0] row_s1
);

	logic valid_s1;
	logic is_red_s1;
	logic frame_start_s1;
	logic frame_end_s1;
	logic in_ready;
	logic accept;
	logic is_red;

	// Hold a frame-end pixel while the previous report is still draining.
	assign in_ready    = ~(valid_s1 & frame_end_s1 & rep_busy);
	assign pixel.ready = in_ready;
	assign accept      = pixel.valid & in_ready;

	assign is_red = (pixel.red >= red_min)
		&& ({1'b0, pixel.green} < green_max)
		&& ({1'b0, pixel.blue} < blue_max);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_red_s1      <= is_red;
			frame_start_s1 <= pixel.frame_start;
			frame_end_s1   <= pixel.frame_end;
			col_s1         <= pixel.col;
			row_s1         <= pixel.row;
		end
	end

	always_comb begin
		ctl.go          = valid_s1 & in_ready;
		ctl.is_red      = is_red_s1;
		ctl.frame_start = frame_start_s1;
		ctl.frame_end   = frame_end_s1;
	end

endmodule

// ===== design/rpct_tracker.sv =====
// Slot bank: distance match, midpoint move, free slot fill and drop count.
// Depends on rpct_pkg.
module rpct_tracker import rpct_pkg::*; #(
	parameter int unsigned SLOT_COUNT = 4,
	parameter int unsigned COORD_BITS = 10,
	parameter int unsigned COUNT_BITS = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pix_ctl_t              ctl,
	input  logic [COORD_BITS-1:0] col_s1,
	input  logic [COORD_BITS-1:0] row_s1,
	input  logic [LIM_BITS-1:0]   lim,
	output logic [COORD_BITS-1:0] col_nxt [SLOT_COUNT],
	output logic [COORD_BITS-1:0] row_nxt [SLOT_COUNT],
	output logic [COUNT_BITS-1:0] hits_nxt [SLOT_COUNT],
	output logic [COUNT_BITS-1:0] drop_nxt
);

	localparam int unsigned SQ_W   = 2 * COORD_BITS;
	localparam int unsigned DIST_W = SQ_W + 1;
	localparam int unsigned CMP_W  = (DIST_W > LIM_BITS) ? DIST_W : LIM_BITS;

	logic [COORD_BITS-1:0] col_q [SLOT_COUNT];
	logic [COORD_BITS-1:0] row_q [SLOT_COUNT];
	logic [COUNT_BITS-1:0] hits_q [SLOT_COUNT];
	logic [COUNT_BITS-1:0] drop_q;

	logic [COORD_BITS-1:0] base_col [SLOT_COUNT];
	logic [COORD_BITS-1:0] base_row [SLOT_COUNT];
	logic [COUNT_BITS-1:0] base_hits [SLOT_COUNT];
	logic [COUNT_BITS-1:0] base_drop;
	logic [COORD_BITS-1:0] dcol [SLOT_COUNT];
	logic [COORD_BITS-1:0] drow [SLOT_COUNT];
	logic [DIST_W-1:0]     dsq [SLOT_COUNT];
	logic [COORD_BITS:0]   sum_col [SLOT_COUNT];
	logic [COORD_BITS:0]   sum_row [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] occ;
	logic [SLOT_COUNT-1:0] match;
	logic [SLOT_COUNT-1:0] fill_oh;
	logic                  have_free;
	logic                  place;

	// Per-slot distance test against the frame-start-cleared view of the bank.
	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			base_col[i]  = ctl.frame_start ? '0 : col_q[i];
			base_row[i]  = ctl.frame_start ? '0 : row_q[i];
			base_hits[i] = ctl.frame_start ? '0 : hits_q[i];
			occ[i]       = |base_hits[i];
			dcol[i]      = (col_s1 >= base_col[i]) ? col_s1 - base_col[i] : base_col[i] - col_s1;
			drow[i]      = (row_s1 >= base_row[i]) ? row_s1 - base_row[i] : base_row[i] - row_s1;
			dsq[i]       = DIST_W'(SQ_W'(dcol[i]) * SQ_W'(dcol[i]))
				+ DIST_W'(SQ_W'(drow[i]) * SQ_W'(drow[i]));
			match[i]     = ctl.is_red & occ[i] & (CMP_W'(dsq[i]) < CMP_W'(lim));
			sum_col[i]   = {1'b0, base_col[i]} + {1'b0, col_s1};
			sum_row[i]   = {1'b0, base_row[i]} + {1'b0, row_s1};
		end
	end

	// Pick the highest-indexed free slot.
	always_comb begin
		have_free = 1'b0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			fill_oh[i] = ~occ[i] & ~have_free;
			have_free  = have_free | ~occ[i];
		end
	end

	assign base_drop = ctl.frame_start ? '0 : drop_q;
	assign place     = ctl.is_red & ~(|match);

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (match[i]) begin
				col_nxt[i]  = sum_col[i][COORD_BITS:1];
				row_nxt[i]  = sum_row[i][COORD_BITS:1];
				hits_nxt[i] = (&base_hits[i]) ? base_hits[i] : base_hits[i] + 1'b1;
			end else if (place & fill_oh[i]) begin
				col_nxt[i]  = col_s1;
				row_nxt[i]  = row_s1;
				hits_nxt[i] = COUNT_BITS'(1);
			end else begin
				col_nxt[i]  = base_col[i];
				row_nxt[i]  = base_row[i];
				hits_nxt[i] = base_hits[i];
			end
		end
		if (place & ~have_free & ~(&base_drop)) begin
			drop_nxt = base_drop + 1'b1;
		end else begin
			drop_nxt = base_drop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				col_q[i]  <= '0;
				row_q[i]  <= '0;
				hits_q[i] <= '0;
			end
			drop_q <= '0;
		end else if (ctl.go) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				col_q[i]  <= col_nxt[i];
				row_q[i]  <= row_nxt[i];
				hits_q[i] <= hits_nxt[i];
			end
			drop_q <= drop_nxt;
		end
	end

endmodule

// ===== design/rpct_report.sv =====
// Report buffer: snapshots the slot bank at frame end and sends one beat per slot.
// Depends on rpct_pkg and rpt_if.
module rpct_report import rpct_pkg::*; #(
	parameter int unsigned SLOT_COUNT = 4,
	parameter int unsigned SLOT_BITS  = 2,
	parameter int unsigned COORD_BITS = 10,
	parameter int unsigned COUNT_BITS = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pix_ctl_t              ctl,
	input  logic [COORD_BITS-1:0] col_nxt [SLOT_COUNT],
	input  logic [COORD_BITS-1:0] row_nxt [SLOT_COUNT],
	input  logic [COUNT_BITS-1:0] hits_nxt [SLOT_COUNT],
	input  logic [COUNT_BITS-1:0] drop_nxt,
	rpt_if.source                 report,
	output logic                  busy
);

	logic [COORD_BITS-1:0] snap_col_q [SLOT_COUNT];
	logic [COORD_BITS-1:0] snap_row_q [SLOT_COUNT];
	logic [COUNT_BITS-1:0] snap_hits_q [SLOT_COUNT];
	logic [COUNT_BITS-1:0] snap_drop_q;
	logic                  busy_q;
	logic [SLOT_BITS-1:0]  idx_q;
	logic                  load;
	logic                  beat;
	logic                  last_slot;

	assign load      = ctl.go & ctl.frame_end;
	assign beat      = busy_q & report.ready;
	assign last_slot = (idx_q == SLOT_BITS'(SLOT_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (beat) begin
			if (last_slot) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Advance the snapshot one slot per beat; the head is always on the port.
	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				snap_col_q[i]  <= col_nxt[i];
				snap_row_q[i]  <= row_nxt[i];
				snap_hits_q[i] <= hits_nxt[i];
			end
			snap_drop_q <= drop_nxt;
		end else if (beat) begin
			for (int i = 0; i < SLOT_COUNT - 1; i++) begin
				snap_col_q[i]  <= snap_col_q[i+1];
				snap_row_q[i]  <= snap_row_q[i+1];
				snap_hits_q[i] <= snap_hits_q[i+1];
			end
		end
	end

	assign report.valid      = busy_q;
	assign report.slot_index = idx_q;
	assign report.center_col = snap_col_q[0];
	assign report.center_row = snap_row_q[0];
	assign report.hit_count  = snap_hits_q[0];
	assign report.dropped    = snap_drop_q;
	assign report.last       = last_slot;
	assign busy              = busy_q;

endmodule

// ===== design/red_pixel_cluster_tracker.sv =====
// Order: a pixel updates the slots as it leaves the input register; a frame-end
// pixel's first report beat is offered along with that update, SLOT_COUNT beats in all.
// Throughput: one pixel per cycle; a frame-end pixel waits in the input register
// only while the previous frame's report is still draining (SLOT_COUNT beats).
// Reset (arst_n low, asynchronous): slots, drop count and handshake state clear,
// thresholds return to red_min 200, green_max 50, blue_max 50, match_radius 50.
module red_pixel_cluster_tracker import rpct_pkg::*; #(
	parameter int unsigned SLOT_COUNT = 4,
	parameter int unsigned COORD_BITS = 10,
	parameter int unsigned COUNT_BITS = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	pix_if.sink                       pixel,
	rpt_if.source                     report,
	input  logic                      cfg_wr_en,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int unsigned SLOT_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	// Threshold registers. The radius is kept only as its square: the match
	// test compares squared distances, so the square is formed once per write.
	logic [CHAN_BITS-1:0]  red_min_q;
	logic [LEVEL_BITS-1:0] green_max_q;
	logic [LEVEL_BITS-1:0] blue_max_q;
	logic [LIM_BITS-1:0]   lim_q;

	pix_ctl_t              ctl;
	logic [COORD_BITS-1:0] col_s1;
	logic [COORD_BITS-1:0] row_s1;
	logic [COORD_BITS-1:0] col_nxt [SLOT_COUNT];
	logic [COORD_BITS-1:0] row_nxt [SLOT_COUNT];
	logic [COUNT_BITS-1:0] hits_nxt [SLOT_COUNT];
	logic [COUNT_BITS-1:0] drop_nxt;
	logic                  rep_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_min_q   <= RED_MIN_RST;
			green_max_q <= GREEN_MAX_RST;
			blue_max_q  <= BLUE_MAX_RST;
			lim_q       <= LIM_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_RED_MIN: begin
					red_min_q <= cfg_data[CHAN_BITS-1:0];
				end
				CFG_GREEN_MAX: begin
					green_max_q <= cfg_data[LEVEL_BITS-1:0];
				end
				CFG_BLUE_MAX: begin
					blue_max_q <= cfg_data[LEVEL_BITS-1:0];
				end
				CFG_MATCH_RADIUS: begin
					lim_q <= radius_sq(cfg_data[RADIUS_BITS-1:0]);
				end
			endcase
		end
	end

	// Input register: classifies the pixel as red on the way in and holds a
	// frame-end pixel back while the report buffer is still occupied.
	rpct_input_stage #(
		.COORD_BITS(COORD_BITS)
	) u_input_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixel    (pixel),
		.red_min  (red_min_q),
		.green_max(green_max_q),
		.blue_max (blue_max_q),
		.rep_busy (rep_busy),
		.ctl      (ctl),
		.col_s1   (col_s1),
		.row_s1   (row_s1)
	);

	// Slot bank: the whole update for one pixel (clear on frame start, all
	// distance tests in parallel, midpoint moves, free slot fill, drop count)
	// sits between the input register and the slot registers, so the next
	// pixel always sees the bank as the previous one left it.
	rpct_tracker #(
		.SLOT_COUNT(SLOT_COUNT),
		.COORD_BITS(COORD_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.col_s1  (col_s1),
		.row_s1  (row_s1),
		.lim     (lim_q),
		.col_nxt (col_nxt),
		.row_nxt (row_nxt),
		.hits_nxt(hits_nxt),
		.drop_nxt(drop_nxt)
	);

	// Report buffer: takes a copy of the updated bank on a frame-end pixel so
	// that pixels of the next frame can flow while the report drains.
	rpct_report #(
		.SLOT_COUNT(SLOT_COUNT),
		.SLOT_BITS (SLOT_BITS),
		.COORD_BITS(COORD_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_report (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.col_nxt (col_nxt),
		.row_nxt (row_nxt),
		.hits_nxt(hits_nxt),
		.drop_nxt(drop_nxt),
		.report  (report),
		.busy    (rep_busy)
	);

endmodule

// ===== design/rpct_checker.sv =====
// Port-level checks on the slot report stream of the tracker, bound to the top level.
// Depends on red_pixel_cluster_tracker.
module rpct_checker #(
	parameter int unsigned SLOT_COUNT = 4,
	parameter int unsigned SLOT_BITS  = 2,
	parameter int unsigned COUNT_BITS = 20
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  rpt_valid,
	input logic                  rpt_ready,
	input logic [SLOT_BITS-1:0]  slot_index,
	input logic [COUNT_BITS-1:0] dropped,
	input logic                  last
);

	// A report beat, once offered, stays until taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && !rpt_ready |=> rpt_valid)
	else $error("report beat withdrawn before it was taken");

	// Slots are reported in order with no gap inside a frame's report.
	assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && rpt_ready && !last |=>
			rpt_valid && (slot_index == SLOT_BITS'($past(slot_index) + 1'b1)))
	else $error("slot report out of order or broken");

	// Only the highest slot closes the report.
	assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid |-> (last == (slot_index == SLOT_BITS'(SLOT_COUNT - 1))))
	else $error("last flag on the wrong slot");

	// Every beat of one report carries the same drop count.
	assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && rpt_ready && !last |=> dropped == $past(dropped))
	else $error("drop count changed inside a report");

endmodule

bind red_pixel_cluster_tracker rpct_checker #(
	.SLOT_COUNT(SLOT_COUNT),
	.SLOT_BITS (SLOT_BITS),
	.COUNT_BITS(COUNT_BITS)
) u_rpct_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rpt_valid (report.valid),
	.rpt_ready (report.ready),
	.slot_index(report.slot_index),
	.dropped   (report.dropped),
	.last      (report.last)
);
